// File: sv/pqrs_pkg.sv
// ----------------------------------------------------------------------------
// pqrs_pkg
// Shared types and constants for the piece queue with reserve stack.
// ----------------------------------------------------------------------------
package pqrs_pkg;

   localparam int QUEUE_DEPTH_DEF = 5;
   localparam int STACK_DEPTH_DEF = 3;
   localparam int ID_WIDTH_DEF    = 16;

   localparam int CMD_W    = 3;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 3;

   // highest legal piece kind, larger codes are clamped to it
   localparam logic [KIND_W-1:0] KIND_MAX = 3'd4;

   // number of entries exchanged by the swap-three command
   localparam int SWAP_SPAN = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD       = 3'd0,
      CMD_PLAY       = 3'd1,
      CMD_RESERVE    = 3'd2,
      CMD_USE        = 3'd3,
      CMD_SWAP_ONE   = 3'd4,
      CMD_SWAP_THREE = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_QUEUE_EMPTY  = 3'd1,
      ST_STACK_FULL   = 3'd2,
      ST_STACK_EMPTY  = 3'd3,
      ST_SWAP_REFUSED = 3'd4,
      ST_QUEUE_FULL   = 3'd5
   } status_type;

endpackage

// File: sv/pqrs_req_if.sv
// ----------------------------------------------------------------------------
// pqrs_req_if
// Command channel: valid/ready handshake with command and new piece kind.
// ----------------------------------------------------------------------------
interface pqrs_req_if;

   logic                        valid;
   logic                        ready;
   logic [pqrs_pkg::CMD_W-1:0]  cmd;
   logic [pqrs_pkg::KIND_W-1:0] new_kind;

   modport source (output valid, output cmd, output new_kind, input ready);
   modport sink   (input valid, input cmd, input new_kind, output ready);

endinterface

// File: sv/pqrs_rsp_if.sv
// ----------------------------------------------------------------------------
// pqrs_rsp_if
// Result channel: valid/ready handshake with status, removed piece and counts.
// ----------------------------------------------------------------------------
interface pqrs_rsp_if #(
   parameter int ID_WIDTH = pqrs_pkg::ID_WIDTH_DEF,
   parameter int QCNT_W   = $clog2(pqrs_pkg::QUEUE_DEPTH_DEF + 1),
   parameter int SCNT_W   = $clog2(pqrs_pkg::STACK_DEPTH_DEF + 1)
);

   logic                          valid;
   logic                          ready;
   logic [pqrs_pkg::STATUS_W-1:0] status;
   logic [pqrs_pkg::KIND_W-1:0]   piece_kind;
   logic [ID_WIDTH-1:0]           piece_id;
   logic [QCNT_W-1:0]             queue_count;
   logic [SCNT_W-1:0]             stack_count;

   modport source (output valid, output status, output piece_kind, output piece_id,
                   output queue_count, output stack_count, input ready);
   modport sink   (input valid, input status, input piece_kind, input piece_id,
                   input queue_count, input stack_count, output ready);

endinterface

// File: sv/pqrs_engine.sv
// ----------------------------------------------------------------------------
// pqrs_engine
// Queue and stack state with the combinational command execution logic.
// ----------------------------------------------------------------------------
module pqrs_engine #(
   parameter  int QUEUE_DEPTH = pqrs_pkg::QUEUE_DEPTH_DEF,
   parameter  int STACK_DEPTH = pqrs_pkg::STACK_DEPTH_DEF,
   parameter  int ID_WIDTH    = pqrs_pkg::ID_WIDTH_DEF,
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1),
   localparam int SCNT_W      = $clog2(STACK_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        exec_en,
   input  pqrs_pkg::cmd_type           cmd,
   input  logic [pqrs_pkg::KIND_W-1:0] new_kind,
   output pqrs_pkg::status_type        status,
   output logic [pqrs_pkg::KIND_W-1:0] piece_kind,
   output logic [ID_WIDTH-1:0]         piece_id,
   output logic [QCNT_W-1:0]           queue_count,
   output logic [SCNT_W-1:0]           stack_count
);

   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int SIDX_W = $clog2(STACK_DEPTH);

   // queue kept front-aligned: entry 0 is always the head
   logic [pqrs_pkg::KIND_W-1:0] q_kind_ff [QUEUE_DEPTH];
   logic [pqrs_pkg::KIND_W-1:0] q_kind_in [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0]         q_id_ff   [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0]         q_id_in   [QUEUE_DEPTH];
   logic [pqrs_pkg::KIND_W-1:0] s_kind_ff [STACK_DEPTH];
   logic [pqrs_pkg::KIND_W-1:0] s_kind_in [STACK_DEPTH];
   logic [ID_WIDTH-1:0]         s_id_ff   [STACK_DEPTH];
   logic [ID_WIDTH-1:0]         s_id_in   [STACK_DEPTH];

   logic [QCNT_W-1:0]   q_fill_ff, q_fill_in;
   logic [SCNT_W-1:0]   s_fill_ff, s_fill_in;
   logic [ID_WIDTH-1:0] next_id_ff, next_id_in;

   logic [pqrs_pkg::KIND_W-1:0] kind_clamp;
   logic                        q_full, q_empty, s_full, s_empty;
   logic [QCNT_W-1:0]           q_last;
   logic [SCNT_W-1:0]           s_top;
   logic [QIDX_W-1:0]           q_tail_idx, q_last_idx;
   logic [SIDX_W-1:0]           s_push_idx, s_top_idx;

   assign kind_clamp = (new_kind > pqrs_pkg::KIND_MAX) ? pqrs_pkg::KIND_MAX : new_kind;
   assign q_full     = (q_fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_empty    = (q_fill_ff == '0);
   assign s_full     = (s_fill_ff == SCNT_W'(STACK_DEPTH));
   assign s_empty    = (s_fill_ff == '0);
   assign q_last     = q_fill_ff - 1'b1;
   assign s_top      = s_fill_ff - 1'b1;
   assign q_tail_idx = q_fill_ff[QIDX_W-1:0];
   assign q_last_idx = q_last[QIDX_W-1:0];
   assign s_push_idx = s_fill_ff[SIDX_W-1:0];
   assign s_top_idx  = s_top[SIDX_W-1:0];

   always_comb begin
      q_kind_in  = q_kind_ff;
      q_id_in    = q_id_ff;
      s_kind_in  = s_kind_ff;
      s_id_in    = s_id_ff;
      q_fill_in  = q_fill_ff;
      s_fill_in  = s_fill_ff;
      next_id_in = next_id_ff;
      status     = pqrs_pkg::ST_OK;
      piece_kind = '0;
      piece_id   = '0;
      unique case (cmd)
         pqrs_pkg::CMD_LOAD: begin
            if (q_full) begin
               status = pqrs_pkg::ST_QUEUE_FULL;
            end else begin
               q_kind_in[q_tail_idx] = kind_clamp;
               q_id_in[q_tail_idx]   = next_id_ff;
               q_fill_in             = q_fill_ff + 1'b1;
               next_id_in            = next_id_ff + 1'b1;
            end
         end
         pqrs_pkg::CMD_PLAY: begin
            if (q_empty) begin
               status = pqrs_pkg::ST_QUEUE_EMPTY;
            end else begin
               piece_kind = q_kind_ff[0];
               piece_id   = q_id_ff[0];
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  q_kind_in[i] = q_kind_ff[i+1];
                  q_id_in[i]   = q_id_ff[i+1];
               end
               q_kind_in[q_last_idx] = kind_clamp;
               q_id_in[q_last_idx]   = next_id_ff;
               next_id_in            = next_id_ff + 1'b1;
            end
         end
         pqrs_pkg::CMD_RESERVE: begin
            if (q_empty) begin
               status = pqrs_pkg::ST_QUEUE_EMPTY;
            end else if (s_full) begin
               status = pqrs_pkg::ST_STACK_FULL;
            end else begin
               s_kind_in[s_push_idx] = q_kind_ff[0];
               s_id_in[s_push_idx]   = q_id_ff[0];
               s_fill_in             = s_fill_ff + 1'b1;
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  q_kind_in[i] = q_kind_ff[i+1];
                  q_id_in[i]   = q_id_ff[i+1];
               end
               q_kind_in[q_last_idx] = kind_clamp;
               q_id_in[q_last_idx]   = next_id_ff;
               next_id_in            = next_id_ff + 1'b1;
            end
         end
         pqrs_pkg::CMD_USE: begin
            if (s_empty) begin
               status = pqrs_pkg::ST_STACK_EMPTY;
            end else begin
               piece_kind = s_kind_ff[s_top_idx];
               piece_id   = s_id_ff[s_top_idx];
               s_fill_in  = s_top;
            end
         end
         pqrs_pkg::CMD_SWAP_ONE: begin
            if (q_empty || s_empty) begin
               status = pqrs_pkg::ST_SWAP_REFUSED;
            end else begin
               q_kind_in[0]         = s_kind_ff[s_top_idx];
               q_id_in[0]           = s_id_ff[s_top_idx];
               s_kind_in[s_top_idx] = q_kind_ff[0];
               s_id_in[s_top_idx]   = q_id_ff[0];
            end
         end
         pqrs_pkg::CMD_SWAP_THREE: begin
            if ((q_fill_ff < QCNT_W'(pqrs_pkg::SWAP_SPAN)) || !s_full) begin
               status = pqrs_pkg::ST_SWAP_REFUSED;
            end else begin
               for (int k = 0; k < pqrs_pkg::SWAP_SPAN; k++) begin
                  q_kind_in[k] = s_kind_ff[k];
                  q_id_in[k]   = s_id_ff[k];
                  s_kind_in[k] = q_kind_ff[k];
                  s_id_in[k]   = q_id_ff[k];
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign queue_count = q_fill_in;
   assign stack_count = s_fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_fill_ff  <= '0;
         s_fill_ff  <= '0;
         next_id_ff <= ID_WIDTH'(1);
      end else if (exec_en) begin
         q_fill_ff  <= q_fill_in;
         s_fill_ff  <= s_fill_in;
         next_id_ff <= next_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_en) begin
         q_kind_ff <= q_kind_in;
         q_id_ff   <= q_id_in;
         s_kind_ff <= s_kind_in;
         s_id_ff   <= s_id_in;
      end
   end

endmodule

// File: sv/piece_queue_reserve_stack.sv
// ----------------------------------------------------------------------------
// piece_queue_reserve_stack
// Piece queue with reserve stack: command register, execution, result register.
// ----------------------------------------------------------------------------
//   channel   direction  handshake      payload
//   req_bus   in         valid / ready  cmd, new_kind
//   rsp_bus   out        valid / ready  status, piece_kind, piece_id,
//                                       queue_count, stack_count
//
// One command per cycle sustained while rsp_bus.ready is high; commands wait
// in the command register, results are presented from the result register.
// All queue and stack updates happen in the cycle the command moves into the
// result register, so the next command sees them directly.
// Synchronous reset empties queue and stack and sets the id counter to 1.
// A stalled result holds the command register; req_bus.ready drops only when
// both registers are full and rsp_bus.ready is low.
// ----------------------------------------------------------------------------
module piece_queue_reserve_stack #(
   parameter int QUEUE_DEPTH = pqrs_pkg::QUEUE_DEPTH_DEF,
   parameter int STACK_DEPTH = pqrs_pkg::STACK_DEPTH_DEF,
   parameter int ID_WIDTH    = pqrs_pkg::ID_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   pqrs_req_if.sink      req_bus,
   pqrs_rsp_if.source    rsp_bus
);

   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SCNT_W = $clog2(STACK_DEPTH + 1);

   logic                        in_valid_ff, in_valid_in;
   logic [pqrs_pkg::CMD_W-1:0]  in_cmd_ff;
   logic [pqrs_pkg::KIND_W-1:0] in_kind_ff;

   logic                        out_valid_ff, out_valid_in;
   pqrs_pkg::status_type        out_status_ff;
   logic [pqrs_pkg::KIND_W-1:0] out_kind_ff;
   logic [ID_WIDTH-1:0]         out_id_ff;
   logic [QCNT_W-1:0]           out_qcnt_ff;
   logic [SCNT_W-1:0]           out_scnt_ff;

   logic                        out_free, exec_en, req_xfer;
   pqrs_pkg::status_type        ex_status;
   logic [pqrs_pkg::KIND_W-1:0] ex_kind;
   logic [ID_WIDTH-1:0]         ex_id;
   logic [QCNT_W-1:0]           ex_qcnt;
   logic [SCNT_W-1:0]           ex_scnt;

   assign out_free       = !out_valid_ff || rsp_bus.ready;
   assign exec_en        = in_valid_ff && out_free;
   assign req_bus.ready  = !in_valid_ff || out_free;
   assign req_xfer       = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (exec_en ? 1'b0 : in_valid_ff);
   assign out_valid_in = exec_en ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   pqrs_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .STACK_DEPTH (STACK_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .exec_en     (exec_en),
      .cmd         (pqrs_pkg::cmd_type'(in_cmd_ff)),
      .new_kind    (in_kind_ff),
      .status      (ex_status),
      .piece_kind  (ex_kind),
      .piece_id    (ex_id),
      .queue_count (ex_qcnt),
      .stack_count (ex_scnt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_cmd_ff  <= req_bus.cmd;
         in_kind_ff <= req_bus.new_kind;
      end
      if (exec_en) begin
         out_status_ff <= ex_status;
         out_kind_ff   <= ex_kind;
         out_id_ff     <= ex_id;
         out_qcnt_ff   <= ex_qcnt;
         out_scnt_ff   <= ex_scnt;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.status      = out_status_ff;
   assign rsp_bus.piece_kind  = out_kind_ff;
   assign rsp_bus.piece_id    = out_id_ff;
   assign rsp_bus.queue_count = out_qcnt_ff;
   assign rsp_bus.stack_count = out_scnt_ff;

endmodule

// File: sv/pqrs_checker.sv
// ----------------------------------------------------------------------------
// pqrs_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pqrs_checker #(
   parameter  int QUEUE_DEPTH = pqrs_pkg::QUEUE_DEPTH_DEF,
   parameter  int STACK_DEPTH = pqrs_pkg::STACK_DEPTH_DEF,
   parameter  int ID_WIDTH    = pqrs_pkg::ID_WIDTH_DEF,
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1),
   localparam int SCNT_W      = $clog2(STACK_DEPTH + 1)
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pqrs_pkg::STATUS_W-1:0] rsp_status,
   input logic [pqrs_pkg::KIND_W-1:0]   rsp_piece_kind,
   input logic [ID_WIDTH-1:0]           rsp_piece_id,
   input logic [QCNT_W-1:0]             rsp_queue_count,
   input logic [SCNT_W-1:0]             rsp_stack_count
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_piece_id) && $stable(rsp_queue_count))
      else $error("stalled result changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queue_count <= QCNT_W'(QUEUE_DEPTH))
                    && (rsp_stack_count <= SCNT_W'(STACK_DEPTH)))
      else $error("count beyond depth");

   a_refused_no_piece: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != pqrs_pkg::ST_OK)
         |-> (rsp_piece_kind == '0) && (rsp_piece_id == '0))
      else $error("piece reported on failed command");

   a_status_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_status != pqrs_pkg::ST_QUEUE_FULL) || (rsp_queue_count == QCNT_W'(QUEUE_DEPTH)))
         && ((rsp_status != pqrs_pkg::ST_STACK_FULL)
             || (rsp_stack_count == SCNT_W'(STACK_DEPTH)))
         && ((rsp_status != pqrs_pkg::ST_STACK_EMPTY) || (rsp_stack_count == '0))
         && ((rsp_status != pqrs_pkg::ST_QUEUE_EMPTY) || (rsp_queue_count == '0)))
      else $error("status disagrees with counts");

endmodule

bind piece_queue_reserve_stack pqrs_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH),
   .STACK_DEPTH (STACK_DEPTH),
   .ID_WIDTH    (ID_WIDTH)
) u_pqrs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_piece_kind  (rsp_bus.piece_kind),
   .rsp_piece_id    (rsp_bus.piece_id),
   .rsp_queue_count (rsp_bus.queue_count),
   .rsp_stack_count (rsp_bus.stack_count)
);
